[rtl/core/button_debounce_hold_detector_unit_defines.svh]
// assertion macros shared by the debounce and hold detector rtl
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef BUTTON_DEBOUNCE_HOLD_DETECTOR_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BDH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bdh_pkg.sv]
// types and constants for the button debounce and hold detector
// no dependencies
package bdh_pkg;

    localparam int TIMER_W = 16;
    localparam int DEB_W   = 8;
    localparam int HOLD_W  = 16;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd10;
    localparam logic [HOLD_W-1:0] HOLD_RST     = 16'd2000;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DOWN = 4'b0010,
        ST_UP   = 4'b0100,
        ST_HOLD = 4'b1000
    } t_settled;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_RELEASED = 2'd2,
        EV_HOLD     = 2'd3
    } t_event;

    typedef enum logic [0:0] {
        REG_DEBOUNCE = 1'b0,
        REG_HOLD     = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] hold_ticks;
    } t_bdh_cfg;

endpackage

[rtl/core/bdh_cfg.sv]
// apb register file: debounce and hold times
// depends on bdh_pkg
module bdh_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bdh_pkg::ADDR_W-1:0] paddr,
    input  logic [bdh_pkg::APB_W-1:0]  pwdata,
    output logic [bdh_pkg::APB_W-1:0]  prdata,
    output bdh_pkg::t_bdh_cfg          o_cfg
);
    import bdh_pkg::*;

    logic [DEB_W-1:0]  r_deb;
    logic [HOLD_W-1:0] r_hold;
    logic              wr_en;
    t_reg_idx          idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = t_reg_idx'(paddr[ADDR_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb  <= DEBOUNCE_RST;
            r_hold <= HOLD_RST;
        end else if (wr_en) begin
            case (idx)
                REG_DEBOUNCE: r_deb  <= pwdata[DEB_W-1:0];
                REG_HOLD:     r_hold <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_DEBOUNCE: prdata[DEB_W-1:0]  = r_deb;
            REG_HOLD:     prdata[HOLD_W-1:0] = r_hold;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.debounce_ticks = r_deb;
    assign o_cfg.hold_ticks     = r_hold;

endmodule

[rtl/core/bdh_lane.sv]
// one button lane: edge tracking, debounce timer, commit and hold check
// depends on bdh_pkg and the assertion macro header
`include "button_debounce_hold_detector_unit_defines.svh"

module bdh_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_level,
    input  bdh_pkg::t_bdh_cfg i_cfg,
    output bdh_pkg::t_event   o_event
);
    import bdh_pkg::*;

    logic               r_last;
    t_kind              r_pend;
    t_settled           r_settled;
    logic [TIMER_W-1:0] r_elapsed;

    logic               n_last;
    t_kind              n_pend;
    t_settled           n_settled;
    logic [TIMER_W-1:0] n_elapsed;
    logic [TIMER_W-1:0] deb_ext;

    assign deb_ext = {{(TIMER_W-DEB_W){1'b0}}, i_cfg.debounce_ticks};

    always_comb begin
        n_last    = i_level;
        n_pend    = r_pend;
        n_settled = r_settled;
        o_event   = EV_NONE;
        n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

        if ((i_level != r_last) && (r_pend == KIND_NONE)) begin
            n_pend    = i_level ? KIND_PRESS : KIND_RELEASE;
            n_elapsed = '0;
        end

        if (n_pend != KIND_NONE) begin
            if (n_elapsed > deb_ext) begin
                if (i_level && (n_pend == KIND_PRESS)) begin
                    n_pend    = KIND_NONE;
                    n_settled = ST_DOWN;
                    n_elapsed = '0;
                    o_event   = EV_PRESSED;
                end else if (!i_level && (n_pend == KIND_RELEASE)) begin
                    n_pend    = KIND_NONE;
                    n_settled = ST_UP;
                    n_elapsed = '0;
                    o_event   = EV_RELEASED;
                end
            end
        end else if ((r_settled == ST_DOWN) && (n_elapsed >= i_cfg.hold_ticks)) begin
            n_settled = ST_HOLD;
            o_event   = EV_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= 1'b0;
            r_pend    <= KIND_NONE;
            r_settled <= ST_IDLE;
            r_elapsed <= '0;
        end else if (i_adv) begin
            r_last    <= n_last;
            r_pend    <= n_pend;
            r_settled <= n_settled;
            r_elapsed <= n_elapsed;
        end
    end

    `BDH_ASSERT_IMPL(a_hold_only_from_down, i_adv && o_event == EV_HOLD, r_settled == ST_DOWN && r_pend == KIND_NONE, "hold reported outside settled down")
    `BDH_ASSERT_NEXT(a_press_commit, i_adv && o_event == EV_PRESSED, r_settled == ST_DOWN && r_pend == KIND_NONE && r_elapsed == '0, "press commit left stale state")
    `BDH_ASSERT_NEXT(a_idle_keeps_state, !i_adv, $stable(r_elapsed) && $stable(r_pend) && $stable(r_settled), "lane state moved without a tick")

endmodule

[rtl/core/bdh_merge.sv]
// merge stage: packs lane events into one result and buffers it (output reg + skid)
// depends on bdh_pkg and the assertion macro header
`include "button_debounce_hold_detector_unit_defines.svh"

module bdh_merge #(
    parameter int NUM_BUTTONS = 3,
    localparam int EV_W  = 2 * NUM_BUTTONS,
    localparam int OUT_W = ((EV_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [EV_W-1:0]  i_events,
    output logic             o_ready,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [OUT_W-1:0] o_tdata
);
    import bdh_pkg::*;

    logic             r_out_vld;
    logic             r_skid_vld;
    logic [OUT_W-1:0] r_out;
    logic [OUT_W-1:0] r_skid;
    logic             n_out_vld;
    logic             n_skid_vld;
    logic [OUT_W-1:0] n_out;
    logic [OUT_W-1:0] n_skid;
    logic [OUT_W-1:0] packed_ev;
    logic             pop;

    always_comb begin
        packed_ev = '0;
        packed_ev[EV_W-1:0] = i_events;
    end

    assign pop     = r_out_vld & i_tready;
    assign o_ready = ~r_skid_vld;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (!r_out_vld) begin
            n_out_vld = i_push;
            n_out     = packed_ev;
        end else if (pop) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = i_push;
                n_skid     = packed_ev;
            end else begin
                n_out_vld = i_push;
                n_out     = packed_ev;
            end
        end else if (i_push) begin
            n_skid_vld = 1'b1;
            n_skid     = packed_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out;

    `BDH_ASSERT_IMPL(a_skid_implies_out, r_skid_vld, r_out_vld, "skid holds data while output is empty")
    `BDH_ASSERT_NEXT(a_stall_fills_skid, i_push && r_out_vld && !i_tready, r_skid_vld, "stalled transaction not captured in skid")
    `BDH_ASSERT_NEXT(a_skid_moves_up, r_skid_vld && i_tready, r_out == $past(r_skid), "skid entry not forwarded in order")

endmodule

[rtl/core/button_debounce_hold_detector_unit.sv]
// top level of the button debounce and hold detector
// depends on bdh_pkg, bdh_cfg, bdh_lane, bdh_merge
//
// channel  | dir | handshake                  | payload
// s_axis   | in  | tvalid/tready              | tdata: level_usr, level_red, level_blk
// m_axis   | out | tvalid/tready              | tdata: event_usr, event_red, event_blk
// apb      | in  | psel/penable/pwrite/pready | 0x0 debounce_ticks, 0x4 hold_ticks
//
// one tick per clock while s_axis transfers are accepted; each lane updates its timer and state in the accept cycle
// result is registered in the output register, or in the skid entry while the output stalls
// skid entry takes the transaction accepted during a stalled output cycle
// input ready drops while the skid entry is full, in the cycle after a stalled accept
// synchronous active-low reset: lanes idle, timers zero, registers at defaults
// config writes complete in the apb access cycle, pready always high
module button_debounce_hold_detector_unit #(
    parameter int NUM_BUTTONS = 3,
    localparam int IN_W  = ((NUM_BUTTONS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * NUM_BUTTONS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [IN_W-1:0]            i_s_axis_tdata,  // level_usr, level_red, level_blk, pad
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [OUT_W-1:0]           o_m_axis_tdata,  // event_usr, event_red, event_blk, pad
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bdh_pkg::ADDR_W-1:0] paddr,
    input  logic [bdh_pkg::APB_W-1:0]  pwdata,
    output logic [bdh_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);
    import bdh_pkg::*;

    t_bdh_cfg                   cfg;
    logic                       adv;
    logic                       merge_ready;
    logic [2*NUM_BUTTONS-1:0]   events;

    assign pready          = 1'b1;
    assign o_s_axis_tready = merge_ready;
    assign adv             = i_s_axis_tvalid & merge_ready;

    bdh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        t_event lane_ev;

        bdh_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_level (i_s_axis_tdata[g]),
            .i_cfg   (cfg),
            .o_event (lane_ev)
        );

        assign events[2*g +: 2] = lane_ev;
    end

    bdh_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (adv),
        .i_events (events),
        .o_ready  (merge_ready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule
